### hw/rtl/rne_pkg.sv
// ----------------------------------------------------------------------------
// rne_pkg - Roman numeral encoder shared definitions
// Word types, glyph codes and the digit shape tables used by the front end,
// the word queue and the letter sequencer.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int YEAR_W      = 12;
  localparam int GLYPH_W     = 8;
  localparam int DIGIT_W     = 4;
  localparam int NPOS        = 4;   // thousands, hundreds, tens, ones
  localparam int QUEUE_DEPTH = 8;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1000;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd3000;
  localparam logic [YEAR_W-1:0] YEAR_2K  = 12'd2000;

  // Digit positions
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_ONES = 2'd3;

  // Symbol roles inside one digit's shape
  localparam logic [1:0] SYM_UNIT = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_TEN  = 2'd2;

  localparam logic [GLYPH_W-1:0] ASCII_M   = 8'h4D;
  localparam logic [GLYPH_W-1:0] ASCII_D   = 8'h44;
  localparam logic [GLYPH_W-1:0] ASCII_C   = 8'h43;
  localparam logic [GLYPH_W-1:0] ASCII_L   = 8'h4C;
  localparam logic [GLYPH_W-1:0] ASCII_X   = 8'h58;
  localparam logic [GLYPH_W-1:0] ASCII_V   = 8'h56;
  localparam logic [GLYPH_W-1:0] ASCII_I   = 8'h49;
  localparam logic [GLYPH_W-1:0] GLYPH_ERR = 8'h00;

  typedef struct packed {
    logic                           err;
    logic [NPOS-1:0][DIGIT_W-1:0]   dig;   // dig[0] is thousands
  } rne_item_t;

  typedef struct packed {
    logic      vld;
    rne_item_t item;
  } rne_xfer_t;

  // Number of letters a decimal digit expands to
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] len;
    unique case (d)
      4'd0:    len = 3'd0;
      4'd1:    len = 3'd1;
      4'd2:    len = 3'd2;
      4'd3:    len = 3'd3;
      4'd4:    len = 3'd2;
      4'd5:    len = 3'd1;
      4'd6:    len = 3'd2;
      4'd7:    len = 3'd3;
      4'd8:    len = 3'd4;
      4'd9:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Role of letter k within digit d (subtractive form)
  function automatic logic [1:0] digit_sym(input logic [DIGIT_W-1:0] d,
                                           input logic [1:0]         k);
    logic [1:0] sym;
    unique case (d)
      4'd4:                sym = (k == 2'd0) ? SYM_UNIT : SYM_FIVE;
      4'd5:                sym = SYM_FIVE;
      4'd6, 4'd7, 4'd8:    sym = (k == 2'd0) ? SYM_FIVE : SYM_UNIT;
      4'd9:                sym = (k == 2'd0) ? SYM_UNIT : SYM_TEN;
      default:             sym = SYM_UNIT;
    endcase
    return sym;
  endfunction

  // ASCII letter for a role at a digit position
  function automatic logic [GLYPH_W-1:0] pos_letter(input logic [1:0] pos,
                                                    input logic [1:0] sym);
    logic [GLYPH_W-1:0] g;
    unique case (pos)
      POS_THOU: g = ASCII_M;
      POS_HUND: g = (sym == SYM_FIVE) ? ASCII_D : ((sym == SYM_TEN) ? ASCII_M : ASCII_C);
      POS_TENS: g = (sym == SYM_FIVE) ? ASCII_L : ((sym == SYM_TEN) ? ASCII_C : ASCII_X);
      POS_ONES: g = (sym == SYM_FIVE) ? ASCII_V : ((sym == SYM_TEN) ? ASCII_X : ASCII_I);
      default:  g = ASCII_M;
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/rne_front.sv
// ----------------------------------------------------------------------------
// rne_front - accept, range check and decimal digit split
// Three-stage pipe feeding the word queue; a credit counter covering the pipe
// and queue drives busy so the pipe never has to stall.
// ----------------------------------------------------------------------------
module rne_front #(
  parameter int QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rne_pkg::YEAR_W-1:0]  in_year,
  input  logic                        pop,
  output logic                        busy,
  output rne_pkg::rne_xfer_t          push
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          accept;
  logic [CW-1:0] credit_r, credit_nxt;

  // stage 1: range check, thousands digit, remainder below 1000
  logic       s1_vld_r;
  logic       s1_err_r;
  logic [1:0] s1_th_r;
  logic [9:0] s1_rem_r;
  logic       err_c;
  logic [1:0] th_c;
  logic [rne_pkg::YEAR_W-1:0] base_c;
  logic [rne_pkg::YEAR_W-1:0] diff_c;

  // stage 2: hundreds and rem/10 by reciprocal multiply
  logic       s2_vld_r;
  logic       s2_err_r;
  logic [1:0] s2_th_r;
  logic [9:0] s2_rem_r;
  logic [3:0] s2_hund_r;
  logic [6:0] s2_q10_r;
  logic [15:0] prod_h;
  logic [17:0] prod_t;

  // stage 3: tens and ones by constant multiply and subtract
  logic [6:0] tens_w;
  logic [9:0] ones_w;

  assign accept = start & ~busy;
  assign busy   = (credit_r == CW'(QUEUE_DEPTH));

  always_comb begin
    credit_nxt = credit_r;
    if (accept && !pop) begin
      credit_nxt = credit_r + CW'(1);
    end else if (!accept && pop) begin
      credit_nxt = credit_r - CW'(1);
    end
  end

  always_comb begin
    err_c = (in_year < rne_pkg::YEAR_MIN) || (in_year > rne_pkg::YEAR_MAX);
    priority if (in_year >= rne_pkg::YEAR_MAX) begin
      th_c   = 2'd3;
      base_c = rne_pkg::YEAR_MAX;
    end else if (in_year >= rne_pkg::YEAR_2K) begin
      th_c   = 2'd2;
      base_c = rne_pkg::YEAR_2K;
    end else begin
      th_c   = 2'd1;
      base_c = rne_pkg::YEAR_MIN;
    end
    diff_c = in_year - base_c;
  end

  // x/100 == (x*41)>>12 and x/10 == (x*205)>>11 for x below 1000
  assign prod_h = {6'd0, s1_rem_r} * 16'd41;
  assign prod_t = {8'd0, s1_rem_r} * 18'd205;

  assign tens_w = s2_q10_r - 7'({3'd0, s2_hund_r} * 7'd10);
  assign ones_w = s2_rem_r - 10'({3'd0, s2_q10_r} * 10'd10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_err_r  <= err_c;
    s1_th_r   <= th_c;
    s1_rem_r  <= diff_c[9:0];
    s2_err_r  <= s1_err_r;
    s2_th_r   <= s1_th_r;
    s2_rem_r  <= s1_rem_r;
    s2_hund_r <= prod_h[15:12];
    s2_q10_r  <= prod_t[17:11];
  end

  always_comb begin
    push.vld                          = s2_vld_r;
    push.item.err                     = s2_err_r;
    push.item.dig[rne_pkg::POS_THOU]  = {2'd0, s2_th_r};
    push.item.dig[rne_pkg::POS_HUND]  = s2_hund_r;
    push.item.dig[rne_pkg::POS_TENS]  = tens_w[3:0];
    push.item.dig[rne_pkg::POS_ONES]  = ones_w[3:0];
  end

endmodule

### hw/rtl/rne_queue.sv
// ----------------------------------------------------------------------------
// rne_queue - word queue between front end and letter sequencer
// Small flop FIFO; occupancy is bounded upstream by the credit counter.
// ----------------------------------------------------------------------------
module rne_queue #(
  parameter int QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rne_pkg::rne_xfer_t push,
  input  logic               pop,
  output rne_pkg::rne_xfer_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rne_pkg::rne_item_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.vld) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push.vld && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push.vld && pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign head.vld  = (count_r != '0);
  assign head.item = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> (count_r < CW'(QUEUE_DEPTH)))
    else $error("word queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("word queue read while empty");

endmodule

### hw/rtl/rne_back.sv
// ----------------------------------------------------------------------------
// rne_back - letter sequencer
// Walks the digits of one word, one letter per cycle, skipping zero digits,
// and loads the next word in the cycle its last letter goes out.
// ----------------------------------------------------------------------------
module rne_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rne_pkg::rne_xfer_t            head,
  output logic                          pop,
  output logic                          out_valid,
  output logic [rne_pkg::GLYPH_W-1:0]   out_glyph,
  output logic                          out_last,
  output logic                          out_out_of_range
);

  logic                                            act_r, act_nxt;
  logic                                            err_r, err_nxt;
  logic [rne_pkg::NPOS-1:0][rne_pkg::DIGIT_W-1:0]  dig_r, dig_nxt;
  logic [1:0]                                      pos_r, pos_nxt;
  logic [1:0]                                      k_r, k_nxt;

  logic                          oval_r;
  logic [rne_pkg::GLYPH_W-1:0]   oglyph_r;
  logic                          olast_r;
  logic                          oerr_r;

  logic [rne_pkg::DIGIT_W-1:0]   cur_dig;
  logic [2:0]                    cur_len;
  logic                          end_of_dig;
  logic                          has_next;
  logic [1:0]                    next_pos;
  logic                          last_now;
  logic [rne_pkg::GLYPH_W-1:0]   letter;

  assign cur_dig    = dig_r[pos_r];
  assign cur_len    = rne_pkg::digit_len(cur_dig);
  assign end_of_dig = (({1'b0, k_r} + 3'd1) == cur_len);
  assign letter     = rne_pkg::pos_letter(pos_r, rne_pkg::digit_sym(cur_dig, k_r));

  // nearest nonzero digit after the current one
  always_comb begin
    has_next = 1'b0;
    next_pos = pos_r;
    for (int p = rne_pkg::NPOS - 1; p >= 0; p--) begin
      if ((2'(p) > pos_r) && (dig_r[2'(p)] != '0)) begin
        has_next = 1'b1;
        next_pos = 2'(p);
      end
    end
  end

  assign last_now = err_r | (end_of_dig & ~has_next);
  assign pop      = head.vld & (~act_r | last_now);

  always_comb begin
    act_nxt = act_r;
    err_nxt = err_r;
    dig_nxt = dig_r;
    pos_nxt = pos_r;
    k_nxt   = k_r;
    if (pop) begin
      act_nxt = 1'b1;
      err_nxt = head.item.err;
      dig_nxt = head.item.dig;
      pos_nxt = rne_pkg::POS_THOU;
      k_nxt   = 2'd0;
    end else if (act_r && last_now) begin
      act_nxt = 1'b0;
    end else if (act_r && end_of_dig) begin
      pos_nxt = next_pos;
      k_nxt   = 2'd0;
    end else if (act_r) begin
      k_nxt   = k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      oval_r <= 1'b0;
      pos_r  <= rne_pkg::POS_THOU;
      k_r    <= 2'd0;
    end else begin
      act_r  <= act_nxt;
      oval_r <= act_r;
      pos_r  <= pos_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r    <= err_nxt;
    dig_r    <= dig_nxt;
    oglyph_r <= err_r ? rne_pkg::GLYPH_ERR : letter;
    olast_r  <= last_now;
    oerr_r   <= err_r;
  end

  assign out_valid        = oval_r;
  assign out_glyph        = oglyph_r;
  assign out_last         = olast_r;
  assign out_out_of_range = oerr_r;

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && oerr_r) |-> (olast_r && (oglyph_r == rne_pkg::GLYPH_ERR)))
    else $error("error word not a single zero glyph with last");

  a_on_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !err_r) |-> (cur_len != 3'd0))
    else $error("sequencer parked on a zero digit");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (act_r && (k_r == 2'd0)))
    else $error("word popped but sequencer not started");

endmodule

### hw/rtl/roman_numeral_encoder_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_encoder_top - binary year to Roman numeral letter stream
// Path: an accepted year passes the two front stage registers, the word queue and the
//   sequencer state, and its letters leave through the output registers.
// Throughput: one letter per cycle; a numeral has 1 to 14 letters, and an
//   out-of-range year gives a single error letter.
// busy rises when QUEUE_DEPTH words are in the front pipe and queue together.
// Reset (rst_n low, synchronous) empties pipe, queue and sequencer; the result
//   side has no backpressure, out_valid marks each letter for one cycle.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_top #(
  parameter int QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH   // words in flight, >= 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rne_pkg::YEAR_W-1:0]    in_year,
  output logic                          busy,
  output logic                          out_valid,
  output logic [rne_pkg::GLYPH_W-1:0]   out_glyph,
  output logic                          out_last,
  output logic                          out_out_of_range
);

  // front -> queue word, queue head word, and the pop that frees a credit
  rne_pkg::rne_xfer_t push;
  rne_pkg::rne_xfer_t head;
  logic               pop;

  // Front end: range check, thousands by compare, hundreds/tens/ones by
  // reciprocal multiply over two registered stages.
  rne_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_year (in_year),
    .pop     (pop),
    .busy    (busy),
    .push    (push)
  );

  // Word queue: lets the front keep accepting while long numerals drain.
  rne_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head)
  );

  // Back end: one letter per cycle, next word loaded with the last letter.
  rne_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_glyph        (out_glyph),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb - Roman numeral encoder testbench
// Sends binary years through the command port and checks every letter that
// comes back against a Roman numeral predictor kept in the bench. The years
// are a directed set of edge cases followed by random years, mostly in range.
// Sender idle gaps are random. One quiet window has no gaps, and the sender
// pauses at times until all expected letters are out.
// ----------------------------------------------------------------------------
module tb;

  localparam int YW = rne_pkg::YEAR_W;
  localparam int GW = rne_pkg::GLYPH_W;

  // One expected letter on the result port
  typedef struct {
    logic [GW-1:0] glyph;
    logic          last;
    logic          oor;
  } letter_t;

  // One pending year. hold_till_empty makes the sender wait until every
  // expected letter has come out before it sends this word.
  typedef struct {
    logic [YW-1:0] year;
    bit            hold_till_empty;
  } year_req_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [YW-1:0] in_year = '0;
  logic          busy;
  logic          out_valid;
  logic [GW-1:0] out_glyph;
  logic          out_last;
  logic          out_out_of_range;

  year_req_t year_q[$];     // years still to send
  letter_t   roman_q[$];    // letters still expected from the encoder

  int n_sent       = 0;
  int n_years      = 0;
  int n_bad_years  = 0;
  int n_letters    = 0;
  int n_mismatch   = 0;
  bit accepted_now;
  bit quiet;
  bit idle;

  roman_numeral_encoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_year          (in_year),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_glyph        (out_glyph),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Appends the letters of one year to the expectation store.
  // Out-of-range years give one error word; in range, each decimal digit is
  // written with its position's unit, five and ten letters, subtractive form.
  function automatic void spell_roman(input logic [YW-1:0] yr);
    logic [GW-1:0] g_q[$];
    logic [GW-1:0] one_l, five_l, ten_l;
    letter_t       l;
    int            div, d;
    if (yr < rne_pkg::YEAR_MIN || yr > rne_pkg::YEAR_MAX) begin
      l.glyph = rne_pkg::GLYPH_ERR;
      l.last  = 1'b1;
      l.oor   = 1'b1;
      roman_q.push_back(l);
      return;
    end
    div = 1000;
    for (int p = 0; p < rne_pkg::NPOS; p++) begin
      d = (int'(yr) / div) % 10;
      case (p)
        0: begin
          one_l = rne_pkg::ASCII_M; five_l = rne_pkg::ASCII_M; ten_l = rne_pkg::ASCII_M;
        end
        1: begin
          one_l = rne_pkg::ASCII_C; five_l = rne_pkg::ASCII_D; ten_l = rne_pkg::ASCII_M;
        end
        2: begin
          one_l = rne_pkg::ASCII_X; five_l = rne_pkg::ASCII_L; ten_l = rne_pkg::ASCII_C;
        end
        default: begin
          one_l = rne_pkg::ASCII_I; five_l = rne_pkg::ASCII_V; ten_l = rne_pkg::ASCII_X;
        end
      endcase
      case (d)
        1, 2, 3: repeat (d) g_q.push_back(one_l);
        4: begin
          g_q.push_back(one_l);
          g_q.push_back(five_l);
        end
        5, 6, 7, 8: begin
          g_q.push_back(five_l);
          repeat (d - 5) g_q.push_back(one_l);
        end
        9: begin
          g_q.push_back(one_l);
          g_q.push_back(ten_l);
        end
        default: ;  // zero digit writes nothing
      endcase
      div = div / 10;
    end
    foreach (g_q[i]) begin
      l.glyph = g_q[i];
      l.last  = (i == g_q.size() - 1);
      l.oor   = 1'b0;
      roman_q.push_back(l);
    end
  endfunction

  // Driver: a word is taken at an edge with start high and busy low.
  // While busy holds it off, start and the year stay put. Otherwise the next
  // year goes out unless this cycle idles or a drain pause is pending.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted_now = start && !busy;
      quiet = (n_sent >= 150 && n_sent < 240);   // gap-free window
      idle  = !quiet && ($urandom_range(99) < 25);
      if (start && busy) begin
        // held off: keep start and in_year as they are
      end else if (year_q.size() != 0 && !idle &&
                   !(year_q[0].hold_till_empty &&
                     (accepted_now || roman_q.size() != 0))) begin
        start   <= 1'b1;
        in_year <= year_q[0].year;
        year_q.pop_front();
        n_sent++;
      end else begin
        start   <= 1'b0;
        in_year <= YW'($urandom);   // noise while start is low
      end
    end
  end

  // Monitor: checks letters first, then records the expectations of a word
  // taken at this edge. Results trail the accepting edge through the front, queue
  // and sequencer registers, so a word never has its own letters on the port at the edge it is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (roman_q.size() == 0) begin
          $display("%0t: unexpected letter glyph=%h last=%b oor=%b",
                   $time, out_glyph, out_last, out_out_of_range);
          n_mismatch++;
        end else begin
          if (out_glyph !== roman_q[0].glyph) begin
            $display("%0t: glyph mismatch, expected %h, got %h",
                     $time, roman_q[0].glyph, out_glyph);
            n_mismatch++;
          end
          if (out_last !== roman_q[0].last) begin
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, roman_q[0].last, out_last);
            n_mismatch++;
          end
          if (out_out_of_range !== roman_q[0].oor) begin
            $display("%0t: out_of_range mismatch, expected %b, got %b",
                     $time, roman_q[0].oor, out_out_of_range);
            n_mismatch++;
          end
          roman_q.pop_front();
          n_letters++;
        end
      end
      if (start && !busy) begin
        spell_roman(in_year);
        n_years++;
        if (in_year < rne_pkg::YEAR_MIN || in_year > rne_pkg::YEAR_MAX)
          n_bad_years++;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    year_req_t r;
    logic [YW-1:0] directed[$];
    directed = '{12'd1000, 12'd3000, 12'd999, 12'd0, 12'd4095, 12'd3001,
                 12'd2888, 12'd1999, 12'd1444, 12'd1666, 12'd2949, 12'd1494,
                 12'd1004, 12'd1009, 12'd1040, 12'd1090, 12'd1400, 12'd1900,
                 12'd1500, 12'd2555, 12'd1777, 12'd2048, 12'd1365};
    foreach (directed[i]) begin
      r.year = directed[i];
      r.hold_till_empty = 1'b0;
      year_q.push_back(r);
    end
    // random part: three in four years in range, the rest split below/above
    for (int i = 0; i < 360; i++) begin
      case ($urandom_range(7))
        0:       r.year = YW'($urandom_range(999));
        1:       r.year = YW'($urandom_range(4095, 3001));
        default: r.year = YW'($urandom_range(3000, 1000));
      endcase
      // drain pauses: first random word, one mid-run, and a few at random
      r.hold_till_empty = (i == 0) || (i == 200) || ($urandom_range(59) == 0);
      year_q.push_back(r);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (year_q.size() != 0 || start) @(posedge clk);
    while (roman_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);   // catch stray letters past the pipe latency

    $display("Run covered %0d years (%0d out of range), %0d letters checked.",
             n_years, n_bad_years, n_letters);
    if (n_mismatch == 0 && roman_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #3000000;
    $display("Timeout with %0d letters outstanding", roman_q.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/rne_pkg.sv
hw/rtl/rne_front.sv
hw/rtl/rne_queue.sv
hw/rtl/rne_back.sv
hw/rtl/roman_numeral_encoder_top.sv
test/tb.sv
